// ===== design/keyframe_sampler_lerp_assert.svh =====
// Assertion macros for the keyframe sampler.
`ifndef KEYFRAME_SAMPLER_LERP_ASSERT_SVH
`define KEYFRAME_SAMPLER_LERP_ASSERT_SVH

// Same-cycle implication, sampled on clk, off during reset
`define KSL_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("keyframe sampler check failed");

// Next-cycle implication, sampled on clk, off during reset
`define KSL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("keyframe sampler check failed");

`endif

// ===== design/ksl_pkg.sv =====
// Shared types and constants for the keyframe sampler.
package ksl_pkg;

    localparam int MAX_KEYS  = 64;
    localparam int FRAC_BITS = 16;
    localparam int AW        = 6;    // key table address width
    localparam int NW        = 7;    // key count width
    localparam int TW        = 32;   // time width
    localparam int VW        = 32;   // value width
    localparam int WW        = 17;   // weight width
    localparam int PW        = WW + 1 + VW + 1;   // lerp product width

    localparam logic [WW-1:0] W_ONE = WW'(1) << FRAC_BITS;

    localparam logic [1:0] OP_LOAD    = 2'd0;
    localparam logic [1:0] OP_ADVANCE = 2'd1;
    localparam logic [1:0] OP_SAMPLE  = 2'd2;

    localparam logic [1:0] ST_INSIDE = 2'd0;
    localparam logic [1:0] ST_BEFORE = 2'd1;
    localparam logic [1:0] ST_PAST   = 2'd2;
    localparam logic [1:0] ST_UNDER  = 2'd3;

    localparam logic [1:0] REG_KEY_COUNT  = 2'd0;
    localparam logic [1:0] REG_ANIM_START = 2'd1;
    localparam logic [1:0] REG_ANIM_END   = 2'd2;

    // Table read address select
    typedef enum logic [2:0] {
        RD_ZERO = 3'd0,
        RD_LAST = 3'd1,
        RD_CUR  = 3'd2,
        RD_CUR1 = 3'd3,
        RD_CUR2 = 3'd4,
        RD_IDX  = 3'd5,
        RD_IDX1 = 3'd6
    } rd_sel_t;

    // Early result set by the controller
    typedef enum logic [1:0] {
        RES_NONE   = 2'd0,
        RES_UNDER  = 2'd1,
        RES_BEFORE = 2'd2,
        RES_PAST   = 2'd3
    } res_code_t;

    typedef struct packed {
        logic       [TW-1:0] t;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
    } key_entry_t;

    typedef struct packed {
        logic      capture;
        logic      div_step;
        logic      wrap;
        rd_sel_t   rd_sel;
        res_code_t res_code;
        logic      cache_upd;
        logic      ka_load;
        logic      advance;
        logic      hit;
        logic      w_load;
        logic      a_load;
        logic      b_load;
        logic      mul;
        logic      out_load;
    } ksl_cmd_t;

    typedef struct packed {
        logic is_sample;
        logic period_nz;
        logic under_two;
        logic before_first;
        logic past_end;
        logic cur_ok;
        logic next_ok;
        logic hit;
        logic out_busy;
    } ksl_stat_t;

endpackage

// ===== design/ksl_ctrl.sv =====
// Sequencing state machine of the keyframe sampler.
module ksl_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  ksl_pkg::ksl_stat_t stat,
    output ksl_pkg::ksl_cmd_t  cmd
);

    typedef enum logic [14:0] {
        S_IDLE = 15'b000000000000001,
        S_REM  = 15'b000000000000010,
        S_WRAP = 15'b000000000000100,
        S_CHK0 = 15'b000000000001000,
        S_CHKL = 15'b000000000010000,
        S_SRD  = 15'b000000000100000,
        S_SA   = 15'b000000001000000,
        S_SB   = 15'b000000010000000,
        S_WDIV = 15'b000000100000000,
        S_WSET = 15'b000001000000000,
        S_RDA  = 15'b000010000000000,
        S_RDB  = 15'b000100000000000,
        S_RDC  = 15'b001000000000000,
        S_MUL  = 15'b010000000000000,
        S_DONE = 15'b100000000000000
    } state_t;

    state_t     state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;

    assign in_ready = (state_reg == S_IDLE);

    // Next state and commands
    always_comb
    begin
        state_next   = state_reg;
        cnt_next     = cnt_reg + 5'd1;
        cmd          = '0;
        cmd.rd_sel   = ksl_pkg::RD_ZERO;
        cmd.res_code = ksl_pkg::RES_NONE;
        case (state_reg)
            S_IDLE:
            begin
                cnt_next = '0;
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    if (stat.is_sample)
                        state_next = stat.period_nz ? S_REM : S_WRAP;
                end
            end
            S_REM:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 5'd31)
                    state_next = S_WRAP;
            end
            S_WRAP:
            begin
                cmd.wrap   = 1'b1;
                cmd.rd_sel = ksl_pkg::RD_ZERO;
                state_next = S_CHK0;
            end
            S_CHK0:
            begin
                if (stat.under_two)
                begin
                    cmd.res_code = ksl_pkg::RES_UNDER;
                    state_next   = S_RDA;
                end
                else if (stat.before_first)
                begin
                    cmd.res_code = ksl_pkg::RES_BEFORE;
                    state_next   = S_RDA;
                end
                else
                begin
                    cmd.rd_sel = ksl_pkg::RD_LAST;
                    state_next = S_CHKL;
                end
            end
            S_CHKL:
            begin
                // default outcome is past end; search may still find the interval
                cmd.res_code = ksl_pkg::RES_PAST;
                if (stat.past_end)
                    state_next = S_RDA;
                else
                begin
                    cmd.cache_upd = 1'b1;
                    state_next    = S_SRD;
                end
            end
            S_SRD:
            begin
                cmd.rd_sel = ksl_pkg::RD_CUR;
                state_next = stat.cur_ok ? S_SA : S_RDA;
            end
            S_SA:
            begin
                cmd.ka_load = 1'b1;
                cmd.rd_sel  = ksl_pkg::RD_CUR1;
                state_next  = S_SB;
            end
            S_SB:
            begin
                cnt_next = '0;
                if (stat.hit)
                begin
                    cmd.hit    = 1'b1;
                    state_next = S_WDIV;
                end
                else
                begin
                    cmd.advance = 1'b1;
                    cmd.rd_sel  = ksl_pkg::RD_CUR2;
                    state_next  = stat.next_ok ? S_SB : S_RDA;
                end
            end
            S_WDIV:
            begin
                cmd.div_step = 1'b1;
                if (cnt_reg == 5'(ksl_pkg::FRAC_BITS - 1))
                    state_next = S_WSET;
            end
            S_WSET:
            begin
                cmd.w_load = 1'b1;
                cmd.rd_sel = ksl_pkg::RD_IDX;
                state_next = S_RDB;
            end
            S_RDA:
            begin
                cmd.rd_sel = ksl_pkg::RD_IDX;
                state_next = S_RDB;
            end
            S_RDB:
            begin
                cmd.a_load = 1'b1;
                cmd.rd_sel = ksl_pkg::RD_IDX1;
                state_next = S_RDC;
            end
            S_RDC:
            begin
                cmd.b_load = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and step counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

endmodule

// ===== design/ksl_dp.sv =====
// Datapath of the keyframe sampler: key table, divider, search and lerp registers.
module ksl_dp (
    input  logic                              clk,
    input  logic                              rst_n,
    input  ksl_pkg::ksl_cmd_t                 cmd,
    output ksl_pkg::ksl_stat_t                stat,
    input  logic                              cfg_we,
    input  logic [1:0]                        cfg_index,
    input  logic [31:0]                       cfg_data,
    input  logic [1:0]                        opcode,
    input  logic [ksl_pkg::AW-1:0]            key_index,
    input  logic [ksl_pkg::TW-1:0]            key_time,
    input  logic signed [ksl_pkg::VW-1:0]     val_x,
    input  logic signed [ksl_pkg::VW-1:0]     val_y,
    input  logic signed [ksl_pkg::VW-1:0]     val_z,
    input  logic [ksl_pkg::TW-1:0]            time_value,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic [ksl_pkg::AW-1:0]            frame_index,
    output logic [ksl_pkg::WW-1:0]            weight,
    output logic signed [ksl_pkg::VW-1:0]     out_x,
    output logic signed [ksl_pkg::VW-1:0]     out_y,
    output logic signed [ksl_pkg::VW-1:0]     out_z,
    output logic [1:0]                        status
);

    localparam int TW = ksl_pkg::TW;
    localparam int VW = ksl_pkg::VW;
    localparam int AW = ksl_pkg::AW;
    localparam int NW = ksl_pkg::NW;
    localparam int WW = ksl_pkg::WW;
    localparam int PW = ksl_pkg::PW;

    // Configuration and persistent state
    logic [NW-1:0] key_count_reg;
    logic [TW-1:0] anim_start_reg;
    logic [TW-1:0] anim_end_reg;
    logic [TW-1:0] run_clock_reg;
    logic [TW-1:0] cached_time_reg;
    logic [AW-1:0] cached_index_reg;

    // Working registers
    ksl_pkg::key_entry_t mem [ksl_pkg::MAX_KEYS];
    ksl_pkg::key_entry_t rd_reg;
    ksl_pkg::key_entry_t a_reg;
    ksl_pkg::key_entry_t b_reg;
    logic [TW-1:0] t_reg;
    logic [TW-1:0] ka_reg;
    logic [AW-1:0] cur_reg;
    logic [AW-1:0] idx_reg;
    logic [WW-1:0] w_reg;
    logic [1:0]    st_reg;
    logic [TW-1:0] rem_reg;
    logic [TW-1:0] dvd_reg;
    logic [TW-1:0] dsr_reg;
    logic signed [PW-1:0] px_reg;
    logic signed [PW-1:0] py_reg;
    logic signed [PW-1:0] pz_reg;
    logic          out_valid_reg;
    logic [AW-1:0] frame_index_reg;
    logic [WW-1:0] weight_reg;
    logic signed [VW-1:0] out_x_reg;
    logic signed [VW-1:0] out_y_reg;
    logic signed [VW-1:0] out_z_reg;
    logic [1:0]    status_reg;

    logic [NW-1:0] n;
    logic [TW-1:0] period;
    logic [TW-1:0] clock_sum;
    logic [AW-1:0] rd_addr;
    logic [TW:0]   trial;
    logic          trial_ge;
    logic [TW-1:0] rem_next;

    // weight times value difference; floor shift is a plain slice afterwards
    function automatic logic signed [PW-1:0] lerp_prod(
        input logic signed [VW-1:0] a,
        input logic signed [VW-1:0] b,
        input logic [WW-1:0]        w
    );
        logic signed [VW:0] d;
        d = {b[VW-1], b} - {a[VW-1], a};
        return $signed({1'b0, w}) * d;
    endfunction

    assign n         = (key_count_reg > NW'(ksl_pkg::MAX_KEYS)) ?
                       NW'(ksl_pkg::MAX_KEYS) : key_count_reg;
    assign period    = (anim_end_reg > anim_start_reg) ? anim_end_reg - anim_start_reg : '0;
    assign clock_sum = run_clock_reg + time_value;

    // Table read address
    always_comb
    begin
        case (cmd.rd_sel)
            ksl_pkg::RD_ZERO: rd_addr = '0;
            ksl_pkg::RD_LAST: rd_addr = AW'(n - NW'(1));
            ksl_pkg::RD_CUR:  rd_addr = cur_reg;
            ksl_pkg::RD_CUR1: rd_addr = cur_reg + AW'(1);
            ksl_pkg::RD_CUR2: rd_addr = cur_reg + AW'(2);
            ksl_pkg::RD_IDX:  rd_addr = idx_reg;
            ksl_pkg::RD_IDX1: rd_addr = idx_reg + AW'(1);
            default:          rd_addr = '0;
        endcase
    end

    // Restoring divider step, one quotient bit
    assign trial    = {rem_reg, dvd_reg[TW-1]};
    assign trial_ge = (trial >= {1'b0, dsr_reg});
    assign rem_next = trial_ge ? TW'(trial - {1'b0, dsr_reg}) : trial[TW-1:0];

    // Status to the controller
    always_comb
    begin
        stat.is_sample    = (opcode == ksl_pkg::OP_ADVANCE) || (opcode == ksl_pkg::OP_SAMPLE);
        stat.period_nz    = (period != '0);
        stat.under_two    = (n < NW'(2));
        stat.before_first = (t_reg < rd_reg.t);
        stat.past_end     = (t_reg > rd_reg.t);
        stat.cur_ok       = ({1'b0, cur_reg} + NW'(1)) < n;
        stat.next_ok      = ({1'b0, cur_reg} + NW'(2)) < n;
        stat.hit          = (t_reg >= ka_reg) && (t_reg < rd_reg.t);
        stat.out_busy     = out_valid_reg && !out_ready;
    end

    // Key table
    always_ff @(posedge clk)
    begin
        if (cmd.capture && opcode == ksl_pkg::OP_LOAD)
            mem[key_index] <= '{t: key_time, x: val_x, y: val_y, z: val_z};
        rd_reg <= mem[rd_addr];
    end

    // Configuration, running clock and search cache
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_count_reg    <= '0;
            anim_start_reg   <= '0;
            anim_end_reg     <= '0;
            run_clock_reg    <= '0;
            cached_time_reg  <= '0;
            cached_index_reg <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    ksl_pkg::REG_KEY_COUNT:  key_count_reg  <= cfg_data[NW-1:0];
                    ksl_pkg::REG_ANIM_START: anim_start_reg <= cfg_data;
                    ksl_pkg::REG_ANIM_END:   anim_end_reg   <= cfg_data;
                    default:                 ;
                endcase
            end
            if (cmd.capture && opcode == ksl_pkg::OP_ADVANCE)
                run_clock_reg <= clock_sum;
            if (cmd.cache_upd)
            begin
                cached_time_reg <= t_reg;
                if (t_reg < cached_time_reg)
                    cached_index_reg <= '0;
            end
            if (cmd.hit)
                cached_index_reg <= cur_reg;
            if (cmd.out_load)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // Sample path
    always_ff @(posedge clk)
    begin
        // divider: wrap remainder first, weight quotient later
        if (cmd.capture)
        begin
            rem_reg <= '0;
            dsr_reg <= period;
            dvd_reg <= (opcode == ksl_pkg::OP_ADVANCE) ? clock_sum : time_value;
        end
        else if (cmd.hit)
        begin
            rem_reg <= t_reg - ka_reg;
            dsr_reg <= rd_reg.t - ka_reg;
            dvd_reg <= '0;
        end
        else if (cmd.div_step)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[TW-2:0], trial_ge};
        end

        if (cmd.wrap)
            t_reg <= (period != '0 ? rem_reg : '0) + anim_start_reg;

        // early result codes
        case (cmd.res_code)
            ksl_pkg::RES_UNDER:
            begin
                idx_reg <= '0;
                w_reg   <= '0;
                st_reg  <= ksl_pkg::ST_UNDER;
            end
            ksl_pkg::RES_BEFORE:
            begin
                idx_reg <= '0;
                w_reg   <= '0;
                st_reg  <= ksl_pkg::ST_BEFORE;
            end
            ksl_pkg::RES_PAST:
            begin
                idx_reg <= AW'(n - NW'(2));
                w_reg   <= ksl_pkg::W_ONE;
                st_reg  <= ksl_pkg::ST_PAST;
            end
            default:
            begin
            end
        endcase

        // interval search
        if (cmd.cache_upd)
            cur_reg <= (t_reg < cached_time_reg) ? '0 : cached_index_reg;
        else if (cmd.advance)
            cur_reg <= cur_reg + AW'(1);
        if (cmd.ka_load)
            ka_reg <= rd_reg.t;
        else if (cmd.advance)
            ka_reg <= rd_reg.t;
        if (cmd.hit)
        begin
            idx_reg <= cur_reg;
            st_reg  <= ksl_pkg::ST_INSIDE;
        end
        if (cmd.w_load)
            w_reg <= {1'b0, dvd_reg[ksl_pkg::FRAC_BITS-1:0]};

        // interpolation; zero weight gives key a as is, whatever the upper key holds
        if (cmd.a_load)
            a_reg <= rd_reg;
        if (cmd.b_load)
            b_reg <= rd_reg;
        if (cmd.mul)
        begin
            px_reg <= (w_reg == '0) ? '0 : lerp_prod(a_reg.x, b_reg.x, w_reg);
            py_reg <= (w_reg == '0) ? '0 : lerp_prod(a_reg.y, b_reg.y, w_reg);
            pz_reg <= (w_reg == '0) ? '0 : lerp_prod(a_reg.z, b_reg.z, w_reg);
        end

        // output word
        if (cmd.out_load)
        begin
            frame_index_reg <= idx_reg;
            weight_reg      <= w_reg;
            status_reg      <= st_reg;
            out_x_reg       <= a_reg.x + px_reg[ksl_pkg::FRAC_BITS +: VW];
            out_y_reg       <= a_reg.y + py_reg[ksl_pkg::FRAC_BITS +: VW];
            out_z_reg       <= a_reg.z + pz_reg[ksl_pkg::FRAC_BITS +: VW];
        end
    end

    assign out_valid   = out_valid_reg;
    assign frame_index = frame_index_reg;
    assign weight      = weight_reg;
    assign out_x       = out_x_reg;
    assign out_y       = out_y_reg;
    assign out_z       = out_z_reg;
    assign status      = status_reg;

endmodule

// ===== design/keyframe_sampler_lerp.sv =====
// Top level of the keyframe sampler with linear interpolation.
// Takes one input word at a time. A load word gives no result and leaves the block ready.
// A sample or advance word first takes the bit-serial remainder of its time when the loop
// period is non-zero, then wraps the time into the window and checks it against the first
// key and then the last key, unless it has under two keys or is clamped before the first.
// If it lies inside, the interval search walks the keys from the cached index, and a hit
// divides out the weight bit-serially. Finally it reads the two keys and multiplies. The key
// table has one read port, so the search reads one key at a time. The result sits in an
// output register, so the next word is taken while it waits; the following result stalls
// in the last state until the receiver has taken the one before.
module keyframe_sampler_lerp (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [1:0]                    opcode,
    input  logic [ksl_pkg::AW-1:0]        key_index,
    input  logic [ksl_pkg::TW-1:0]        key_time,
    input  logic signed [ksl_pkg::VW-1:0] val_x,
    input  logic signed [ksl_pkg::VW-1:0] val_y,
    input  logic signed [ksl_pkg::VW-1:0] val_z,
    input  logic [ksl_pkg::TW-1:0]        time_value,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic [ksl_pkg::AW-1:0]        frame_index,
    output logic [ksl_pkg::WW-1:0]        weight,
    output logic signed [ksl_pkg::VW-1:0] out_x,
    output logic signed [ksl_pkg::VW-1:0] out_y,
    output logic signed [ksl_pkg::VW-1:0] out_z,
    output logic [1:0]                    status
);

`include "keyframe_sampler_lerp_assert.svh"

    ksl_pkg::ksl_cmd_t  cmd;
    ksl_pkg::ksl_stat_t stat;

    ksl_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ksl_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .stat        (stat),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .opcode      (opcode),
        .key_index   (key_index),
        .key_time    (key_time),
        .val_x       (val_x),
        .val_y       (val_y),
        .val_z       (val_z),
        .time_value  (time_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_index (frame_index),
        .weight      (weight),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .status      (status)
    );

    // Checks on result words and input flow
    `KSL_ASSERT_IMP(a_inside_weight, out_valid && status == ksl_pkg::ST_INSIDE, weight < ksl_pkg::W_ONE)
    `KSL_ASSERT_IMP(a_past_weight, out_valid && status == ksl_pkg::ST_PAST, weight == ksl_pkg::W_ONE)
    `KSL_ASSERT_IMP(a_clamp_zero, out_valid && (status == ksl_pkg::ST_BEFORE || status == ksl_pkg::ST_UNDER), weight == '0 && frame_index == '0)
    `KSL_ASSERT_NEXT(a_sample_busy, in_valid && in_ready && (opcode == ksl_pkg::OP_ADVANCE || opcode == ksl_pkg::OP_SAMPLE), !in_ready)

endmodule

// ===== test/keyframe_sampler_lerp_tb.sv =====
// Self-checking testbench for the keyframe sampler with linear interpolation.
module keyframe_sampler_lerp_tb;
    import ksl_pkg::*;

    localparam logic [1:0] OP_NONE = 2'd3;     // unused opcode, ignored by the block
    localparam int SETTLE_CYCLES = 200;
    localparam int CYCLE_LIMIT   = 3000000;

    typedef struct packed {
        logic [AW-1:0]        frame_index;
        logic [WW-1:0]        weight;
        logic signed [VW-1:0] x;
        logic signed [VW-1:0] y;
        logic signed [VW-1:0] z;
        logic [1:0]           status;
    } sample_res_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [31:0]          cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [1:0]           opcode;
    logic [AW-1:0]        key_index;
    logic [TW-1:0]        key_time;
    logic signed [VW-1:0] val_x;
    logic signed [VW-1:0] val_y;
    logic signed [VW-1:0] val_z;
    logic [TW-1:0]        time_value;
    logic                 out_valid;
    logic                 out_ready;
    logic [AW-1:0]        frame_index;
    logic [WW-1:0]        weight;
    logic signed [VW-1:0] out_x;
    logic signed [VW-1:0] out_y;
    logic signed [VW-1:0] out_z;
    logic [1:0]           status;

    // Predictor state: key table, clock, search cache and registers
    logic [TW-1:0]        tbl_time [MAX_KEYS];
    logic signed [VW-1:0] tbl_x [MAX_KEYS];
    logic signed [VW-1:0] tbl_y [MAX_KEYS];
    logic signed [VW-1:0] tbl_z [MAX_KEYS];
    logic [TW-1:0]        anim_clock;
    logic [TW-1:0]        last_time;
    int unsigned          last_index;
    logic [NW-1:0]        num_keys;
    logic [TW-1:0]        win_start;
    logic [TW-1:0]        win_end;

    sample_res_t expected_samples[$];
    int          fail_count;
    int          cycle_count;
    int          send_idle_pct;
    int          recv_stall_pct;

    keyframe_sampler_lerp i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .opcode      (opcode),
        .key_index   (key_index),
        .key_time    (key_time),
        .val_x       (val_x),
        .val_y       (val_y),
        .val_z       (val_z),
        .time_value  (time_value),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .frame_index (frame_index),
        .weight      (weight),
        .out_x       (out_x),
        .out_y       (out_y),
        .out_z       (out_z),
        .status      (status)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    // Run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver back-pressure
    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Linear blend of one component, rounded toward minus infinity
    function automatic logic signed [VW-1:0] blend(logic signed [VW-1:0] a,
                                                    logic signed [VW-1:0] b,
                                                    logic [WW-1:0] w);
        longint diff;
        longint prod;
        longint wl;
        diff = longint'(b) - longint'(a);
        wl   = longint'(w);
        prod = wl * diff;
        return VW'(longint'(a) + (prod >>> FRAC_BITS));
    endfunction

    // Expected result of a sample at the given raw time; updates the search cache
    function automatic sample_res_t sample_at(logic [TW-1:0] raw);
        sample_res_t r;
        int unsigned n;
        logic [TW-1:0] period;
        logic [TW-1:0] t;
        int unsigned lo;
        logic [63:0] num;
        n = (num_keys > MAX_KEYS) ? MAX_KEYS : num_keys;
        period = (win_end > win_start) ? win_end - win_start : '0;
        t = ((period != 0) ? raw % period : '0) + win_start;
        lo = 0;
        r.weight = '0;
        if (n < 2)
            r.status = ST_UNDER;
        else if (t < tbl_time[0])
            r.status = ST_BEFORE;
        else
        begin
            lo = n - 2;
            r.weight = W_ONE;
            r.status = ST_PAST;
            if (t <= tbl_time[n-1])
            begin
                if (t < last_time)
                    last_index = 0;
                last_time = t;
                for (int unsigned i = last_index; i + 1 < n; i++)
                begin
                    if (t >= tbl_time[i] && t < tbl_time[i+1])
                    begin
                        lo = i;
                        num = 64'(t - tbl_time[i]) << FRAC_BITS;
                        r.weight = WW'(num / 64'(tbl_time[i+1] - tbl_time[i]));
                        last_index = i;
                        r.status = ST_INSIDE;
                        break;
                    end
                end
            end
        end
        r.frame_index = AW'(lo);
        if (n < 2)
        begin
            r.x = tbl_x[0];
            r.y = tbl_y[0];
            r.z = tbl_z[0];
        end
        else
        begin
            r.x = blend(tbl_x[lo], tbl_x[lo+1], r.weight);
            r.y = blend(tbl_y[lo], tbl_y[lo+1], r.weight);
            r.z = blend(tbl_z[lo], tbl_z[lo+1], r.weight);
        end
        return r;
    endfunction

    // Append one expected result word
    task automatic expect_word(sample_res_t r);
        expected_samples = {expected_samples, r};
    endtask

    // Register write, predictor follows; no word is offered meanwhile
    task automatic write_reg(logic [1:0] idx, logic [31:0] data);
        in_valid  <= 1'b0;
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        case (idx)
            REG_KEY_COUNT:  num_keys  = NW'(data);
            REG_ANIM_START: win_start = data;
            REG_ANIM_END:   win_end   = data;
            default: ;
        endcase
    endtask

    // Send one word, predict on acceptance, then maybe idle
    task automatic send_word(logic [1:0] op, logic [AW-1:0] idx, logic [TW-1:0] kt,
                             logic [31:0] vx, logic [31:0] vy, logic [31:0] vz,
                             logic [TW-1:0] tv);
        in_valid   <= 1'b1;
        opcode     <= op;
        key_index  <= idx;
        key_time   <= kt;
        val_x      <= vx;
        val_y      <= vy;
        val_z      <= vz;
        time_value <= tv;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        case (op)
            OP_LOAD:
            begin
                tbl_time[idx] = kt;
                tbl_x[idx] = vx;
                tbl_y[idx] = vy;
                tbl_z[idx] = vz;
            end
            OP_ADVANCE:
            begin
                anim_clock = anim_clock + tv;
                expect_word(sample_at(anim_clock));
            end
            OP_SAMPLE: expect_word(sample_at(tv));
            default: ;
        endcase
        if ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic load_key(int idx, logic [TW-1:0] kt, logic [31:0] vx,
                            logic [31:0] vy, logic [31:0] vz);
        send_word(OP_LOAD, AW'(idx), kt, vx, vy, vz, $urandom);
    endtask

    task automatic sample_word(logic [1:0] op, logic [TW-1:0] tv);
        send_word(op, AW'($urandom), $urandom, $urandom, $urandom, $urandom, tv);
    endtask

    // Drop valid and wait until every result is back and the block has gone quiet
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_samples.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Ascending table with a random step
    task automatic fill_table(logic [TW-1:0] base, int unsigned max_step);
        logic [TW-1:0] kt;
        kt = base;
        for (int i = 0; i < MAX_KEYS; i++)
        begin
            load_key(i, kt, $urandom, $urandom, $urandom);
            kt = kt + $urandom_range(max_step, 1);
        end
    endtask

    // Sample time biased towards the keys and the window
    function automatic logic [TW-1:0] pick_time();
        case ($urandom_range(5))
            0: return $urandom;
            1: return tbl_time[$urandom_range(MAX_KEYS-1)];
            2: return tbl_time[$urandom_range(MAX_KEYS-1)] + $urandom_range(8) - 4;
            default: return tbl_time[0] - 16 + $urandom_range(
                                 tbl_time[MAX_KEYS-1] - tbl_time[0] + 32);
        endcase
    endfunction

    task automatic test_under_two_keys();
        load_key(0, 32'h0001_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000);
        write_reg(REG_KEY_COUNT, 0);
        sample_word(OP_SAMPLE, 32'h0000_0000);
        sample_word(OP_ADVANCE, 32'hFFFF_FFFF);
        drain();
        write_reg(REG_KEY_COUNT, 1);
        sample_word(OP_SAMPLE, 32'h0002_0000);
        drain();
    endtask

    task automatic test_directed();
        fill_table(32'h0001_0000, 32'h0000_4000);
        // steepest possible slope in the last interval
        load_key(MAX_KEYS-1, tbl_time[MAX_KEYS-1], 32'h8000_0000, 32'h7FFF_FFFF, 32'h0);
        load_key(MAX_KEYS-2, tbl_time[MAX_KEYS-2], 32'h7FFF_FFFF, 32'h8000_0000,
                 32'hFFFF_FFFF);
        drain();
        write_reg(REG_KEY_COUNT, MAX_KEYS);
        sample_word(OP_SAMPLE, 32'h0);                       // before first key
        sample_word(OP_SAMPLE, tbl_time[0]);                 // exactly on first key
        sample_word(OP_SAMPLE, tbl_time[10] + 1);
        sample_word(OP_SAMPLE, tbl_time[5]);                 // backward, restarts search
        sample_word(OP_SAMPLE, tbl_time[MAX_KEYS-1] - 1);    // steep interval
        sample_word(OP_SAMPLE, tbl_time[MAX_KEYS-1]);        // equal to last key
        sample_word(OP_SAMPLE, 32'hFFFF_FFFF);               // past end
        sample_word(OP_ADVANCE, tbl_time[3]);
        sample_word(OP_ADVANCE, 32'hFFFF_FFFF);              // clock wraps
        sample_word(OP_ADVANCE, 32'h0);
        sample_word(OP_NONE, 32'h0001_0000);                 // ignored opcode
        drain();
        // over-range key count acts as a full table
        write_reg(REG_KEY_COUNT, 7'h7F);
        sample_word(OP_SAMPLE, tbl_time[40] + 3);
        drain();
        // loop window inside the table
        write_reg(REG_ANIM_START, tbl_time[2]);
        write_reg(REG_ANIM_END, tbl_time[20] + 7);
        sample_word(OP_SAMPLE, 32'hFFFF_FFFF);
        sample_word(OP_SAMPLE, 32'h0);
        sample_word(OP_ADVANCE, 32'h8000_0000);
        drain();
        // end below start falls back to the start
        write_reg(REG_ANIM_START, 32'hFFFF_FFFF);
        write_reg(REG_ANIM_END, 32'h0);
        sample_word(OP_SAMPLE, 32'h1234_5678);
        drain();
        // whole range as window
        write_reg(REG_ANIM_START, 32'h0);
        write_reg(REG_ANIM_END, 32'hFFFF_FFFF);
        sample_word(OP_SAMPLE, 32'hFFFF_FFFE);
        drain();
        write_reg(REG_ANIM_END, 32'h0);
        write_reg(REG_KEY_COUNT, 2);
        sample_word(OP_SAMPLE, tbl_time[1] - 1);
        drain();
    endtask

    // Random phase: mostly samples on an ascending table, some key rewrites
    task automatic test_random_phase(int items, int n_keys, logic [TW-1:0] w_start,
                                     logic [TW-1:0] w_end);
        int k;
        logic [TW-1:0] lo_t;
        logic [TW-1:0] hi_t;
        write_reg(REG_KEY_COUNT, n_keys);
        write_reg(REG_ANIM_START, w_start);
        write_reg(REG_ANIM_END, w_end);
        for (int i = 0; i < items; i++)
        begin
            case ($urandom_range(9))
                0:
                begin
                    k = $urandom_range(MAX_KEYS-1);
                    lo_t = (k == 0) ? 32'h0 : tbl_time[k-1];
                    hi_t = (k == MAX_KEYS-1) ? tbl_time[k] + 32'h100 : tbl_time[k+1];
                    if ($urandom_range(4) == 0 || hi_t <= lo_t)
                        load_key(k, $urandom, $urandom, $urandom, $urandom);
                    else
                        load_key(k, lo_t + $urandom_range(hi_t - lo_t), $urandom,
                                 $urandom, $urandom);
                end
                1, 2, 3: sample_word(OP_ADVANCE, $urandom_range(32'h800));
                4: sample_word(OP_NONE, $urandom);
                default: sample_word(OP_SAMPLE, pick_time());
            endcase
            if (i == items / 2)
            begin
                // hold off until everything outstanding is back
                in_valid <= 1'b0;
                @(posedge clk);
                while (expected_samples.size() != 0)
                    @(posedge clk);
            end
        end
        drain();
    endtask

    task automatic test_random();
        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 80; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 80; end
                default: begin send_idle_pct = 8; recv_stall_pct = 8; end
            endcase
            fill_table($urandom_range(32'h0004_0000), 32'h0000_0800);
            drain();
            test_random_phase(150, $urandom_range(MAX_KEYS, 2), 32'h0, 32'h0);
            test_random_phase(75, $urandom_range(8, 2), tbl_time[0] - 32'h100,
                              tbl_time[MAX_KEYS-1] + 32'h100);
            test_random_phase(75, MAX_KEYS, 32'h0, tbl_time[MAX_KEYS/2]);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        sample_res_t e;
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_samples.size() == 0)
            begin
                $error("unexpected result word");
                fail_count++;
            end
            else
            begin
                e = expected_samples.pop_front();
                if (frame_index !== e.frame_index)
                begin
                    $error("frame_index exp %0d got %0d", e.frame_index, frame_index);
                    fail_count++;
                end
                if (weight !== e.weight)
                begin
                    $error("weight exp %0d got %0d", e.weight, weight);
                    fail_count++;
                end
                if (out_x !== e.x)
                begin
                    $error("out_x exp %0d got %0d", e.x, out_x);
                    fail_count++;
                end
                if (out_y !== e.y)
                begin
                    $error("out_y exp %0d got %0d", e.y, out_y);
                    fail_count++;
                end
                if (out_z !== e.z)
                begin
                    $error("out_z exp %0d got %0d", e.z, out_z);
                    fail_count++;
                end
                if (status !== e.status)
                begin
                    $error("status exp %0d got %0d", e.status, status);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        in_valid = 1'b0;
        opcode = OP_LOAD;
        key_index = '0;
        key_time = '0;
        val_x = '0;
        val_y = '0;
        val_z = '0;
        time_value = '0;
        out_ready = 1'b0;
        fail_count = 0;
        cycle_count = 0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        anim_clock = '0;
        last_time = '0;
        last_index = 0;
        num_keys = '0;
        win_start = '0;
        win_end = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_under_two_keys();
        test_directed();
        test_random();

        if (fail_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
